// ----- rtl/core/pim_pkg.sv -----
// ----------------------------------------------------------------------------
// pim_pkg
// Shared types and codes for the priority inheritance mutex core.
// ----------------------------------------------------------------------------
package pim_pkg;

	localparam int TASK_W          = 4;
	localparam int PRIO_W          = 5;
	localparam int NUM_TASKS_DEF   = 16;
	localparam int PRIO_LEVELS_DEF = 32;
	localparam int MAX_NEST_DEF    = 255;

	typedef enum logic [1:0] {
		ACT_LOCK   = 2'd0,
		ACT_UNLOCK = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_DELETE = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_WOULD_BLOCK = 3'd1,
		ST_QUEUED      = 3'd2,
		ST_NOT_OWNER   = 3'd3,
		ST_NEST_OVF    = 3'd4,
		ST_NOT_WAITING = 3'd5
	} status_t;

	typedef struct packed {
		action_t             action;
		logic [TASK_W-1:0]   task_id;
		logic [PRIO_W-1:0]   task_priority;
		logic                no_wait;
	} req_t;

	// one wait queue entry
	typedef struct packed {
		logic [TASK_W-1:0] tid;
		logic [PRIO_W-1:0] prio;
	} waiter_t;

	typedef struct packed {
		status_t           status;
		logic              prio_change_valid;
		logic [TASK_W-1:0] prio_task;
		logic [PRIO_W-1:0] prio_value;
		logic              wake_valid;
		logic [TASK_W-1:0] wake_task;
		logic              wake_timed_out;
		logic              yield_hint;
		logic              last;
	} result_t;

endpackage

// ----- rtl/core/pim_waitq_ram.sv -----
// ----------------------------------------------------------------------------
// pim_waitq_ram
// Wait queue storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pim_waitq_ram #(
	parameter int DEPTH = pim_pkg::NUM_TASKS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  pim_pkg::waiter_t wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output pim_pkg::waiter_t rdata
);
	import pim_pkg::*;

	waiter_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/pim_seq.sv -----
// ----------------------------------------------------------------------------
// pim_seq
// Mutex sequencer: owner state, decode, and read-modify-write walks over the
// wait queue memory (sorted insert, unlink, head grant, release on delete).
// ----------------------------------------------------------------------------
module pim_seq #(
	parameter int NUM_TASKS   = pim_pkg::NUM_TASKS_DEF,
	parameter int PRIO_LEVELS = pim_pkg::PRIO_LEVELS_DEF,
	parameter int MAX_NEST    = pim_pkg::MAX_NEST_DEF,
	parameter int IDX_W       = $clog2(NUM_TASKS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  pim_pkg::req_t        req,
	output logic                 res_valid,
	input  logic                 res_ready,
	output pim_pkg::result_t     res,
	output logic                 ram_we,
	output logic [IDX_W-1:0]     ram_waddr,
	output pim_pkg::waiter_t     ram_wdata,
	output logic                 ram_re,
	output logic [IDX_W-1:0]     ram_raddr,
	input  pim_pkg::waiter_t     ram_rdata
);
	import pim_pkg::*;

	localparam int CNT_W  = $clog2(NUM_TASKS + 1);
	localparam int NEST_W = $clog2(MAX_NEST + 1);
	localparam int PMAX   = PRIO_LEVELS - 1;
	localparam logic [PRIO_W-1:0] PRIO_TOP =
		(PMAX >= (1 << PRIO_W) - 1) ? {PRIO_W{1'b1}} : PMAX[PRIO_W-1:0];
	localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(NUM_TASKS);
	localparam logic [NEST_W-1:0] NEST_TOP = MAX_NEST[NEST_W-1:0];
	localparam logic [NEST_W-1:0] NEST_ONE = NEST_W'(1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_INS_FIN,
		S_HEAD_RD,
		S_HEAD_USE,
		S_SHF_RD,
		S_SHF_WR,
		S_RM_RD,
		S_RM_CMP,
		S_DEL_RD,
		S_DEL_OUT,
		S_EMIT
	} state_t;

	state_t             state_q;
	logic               owned_q;
	logic [TASK_W-1:0]  owner_q;
	logic [NEST_W-1:0]  nest_q;
	logic [PRIO_W-1:0]  base_q;
	logic [PRIO_W-1:0]  eff_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   idx_q;
	logic [TASK_W-1:0]  req_tid_q;
	logic [PRIO_W-1:0]  req_prio_q;
	result_t            res_q;

	logic [PRIO_W-1:0]  prio_sat;
	logic [CNT_W-1:0]   idx_nx;
	logic               is_owner;
	logic               boost;
	logic               refuse;
	logic               ins_shift;
	logic               del_last;
	result_t            res_d;

	always_comb begin
		prio_sat  = (req.task_priority > PRIO_TOP) ? PRIO_TOP : req.task_priority;
		idx_nx    = CNT_W'(idx_q) + CNT_W'(1);
		is_owner  = owned_q && (owner_q == req.task_id);
		boost     = prio_sat < eff_q;
		refuse    = req.no_wait || (count_q == CNT_FULL);
		ins_shift = ram_rdata.prio > req_prio_q;
		del_last  = idx_nx == count_q;
	end

	// next value of the result register
	always_comb begin
		res_d = res_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					res_d      = '0;
					res_d.last = 1'b1;
					unique case (req.action)
						ACT_LOCK: begin
							if (is_owner) begin
								if (nest_q >= NEST_TOP) begin
									res_d.status = ST_NEST_OVF;
								end
							end else if (owned_q) begin
								if (boost) begin
									res_d.prio_change_valid = 1'b1;
									res_d.prio_task         = owner_q;
									res_d.prio_value        = prio_sat;
								end
								if (refuse) begin
									res_d.status = ST_WOULD_BLOCK;
								end else begin
									res_d.status = ST_QUEUED;
								end
							end
						end
						ACT_UNLOCK: begin
							if (!is_owner) begin
								res_d.status = ST_NOT_OWNER;
							end else if (nest_q <= NEST_ONE) begin
								res_d.prio_change_valid = 1'b1;
								res_d.prio_task         = owner_q;
								res_d.prio_value        = base_q;
							end
						end
						ACT_REMOVE: begin
							if (count_q == '0) begin
								res_d.status = ST_NOT_WAITING;
							end
						end
						ACT_DELETE: begin
							if (owned_q) begin
								res_d.prio_change_valid = 1'b1;
								res_d.prio_task         = owner_q;
								res_d.prio_value        = base_q;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_HEAD_USE: begin
				res_d.wake_valid = 1'b1;
				res_d.wake_task  = ram_rdata.tid;
				res_d.yield_hint = ram_rdata.prio < res_q.prio_value;
			end
			S_RM_CMP: begin
				if (ram_rdata.tid != req_tid_q && !(idx_nx < count_q)) begin
					res_d.status = ST_NOT_WAITING;
				end
			end
			S_DEL_OUT: begin
				if (res_ready) begin
					// restore rides on the first release only
					res_d.prio_change_valid = 1'b0;
					res_d.prio_task         = '0;
					res_d.prio_value        = '0;
				end
			end
			default: begin
			end
		endcase
	end

	// handshakes and memory port control
	always_comb begin
		req_ready = state_q == S_IDLE;
		res_valid = (state_q == S_EMIT) || (state_q == S_DEL_OUT);
		res       = res_q;
		if (state_q == S_DEL_OUT) begin
			res.wake_valid     = 1'b1;
			res.wake_task      = ram_rdata.tid;
			res.wake_timed_out = 1'b1;
			res.last           = del_last;
		end

		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '{tid: req_tid_q, prio: req_prio_q};
		ram_re    = 1'b0;
		ram_raddr = idx_q;

		unique case (state_q) inside
			S_IDLE: begin
				// first waiter goes straight into slot 0
				if (req_valid && req.action == ACT_LOCK && owned_q && !is_owner &&
				    !refuse && count_q == '0) begin
					ram_we    = 1'b1;
					ram_waddr = '0;
					ram_wdata = '{tid: req.task_id, prio: prio_sat};
				end
			end
			S_INS_RD, S_RM_RD, S_DEL_RD: begin
				ram_re = 1'b1;
			end
			S_INS_CMP: begin
				ram_we    = 1'b1;
				ram_waddr = IDX_W'(idx_nx);
				if (ins_shift) begin
					ram_wdata = ram_rdata;
				end
			end
			S_INS_FIN: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
			end
			S_HEAD_RD: begin
				ram_re    = 1'b1;
				ram_raddr = '0;
			end
			S_SHF_RD: begin
				ram_re    = idx_nx < count_q;
				ram_raddr = IDX_W'(idx_nx);
			end
			S_SHF_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			owned_q    <= 1'b0;
			owner_q    <= '0;
			nest_q     <= '0;
			base_q     <= '0;
			eff_q      <= '0;
			count_q    <= '0;
			idx_q      <= '0;
			req_tid_q  <= '0;
			req_prio_q <= '0;
			res_q      <= '0;
		end else begin
			res_q <= res_d;
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_tid_q  <= req.task_id;
						req_prio_q <= prio_sat;
						state_q    <= S_EMIT;
						unique case (req.action)
							ACT_LOCK: begin
								if (!owned_q) begin
									owned_q <= 1'b1;
									owner_q <= req.task_id;
									nest_q  <= NEST_ONE;
									base_q  <= prio_sat;
									eff_q   <= prio_sat;
								end else if (is_owner) begin
									if (nest_q < NEST_TOP) begin
										nest_q <= nest_q + NEST_ONE;
									end
								end else begin
									if (boost) begin
										eff_q <= prio_sat;
									end
									if (!refuse) begin
										if (count_q == '0) begin
											count_q <= CNT_W'(1);
										end else begin
											idx_q   <= IDX_W'(count_q - CNT_W'(1));
											state_q <= S_INS_RD;
										end
									end
								end
							end
							ACT_UNLOCK: begin
								if (is_owner) begin
									if (nest_q > NEST_ONE) begin
										nest_q <= nest_q - NEST_ONE;
									end else begin
										nest_q <= '0;
										eff_q  <= base_q;
										if (count_q != '0) begin
											state_q <= S_HEAD_RD;
										end else begin
											owned_q <= 1'b0;
										end
									end
								end
							end
							ACT_REMOVE: begin
								if (count_q != '0) begin
									idx_q   <= '0;
									state_q <= S_RM_RD;
								end
							end
							ACT_DELETE: begin
								if (owned_q) begin
									eff_q <= base_q;
								end
								if (count_q == '0) begin
									owned_q <= 1'b0;
									nest_q  <= '0;
								end else begin
									idx_q   <= '0;
									state_q <= S_DEL_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_INS_RD: begin
					state_q <= S_INS_CMP;
				end
				S_INS_CMP: begin
					if (ins_shift) begin
						if (idx_q == '0) begin
							state_q <= S_INS_FIN;
						end else begin
							idx_q   <= idx_q - IDX_W'(1);
							state_q <= S_INS_RD;
						end
					end else begin
						count_q <= count_q + CNT_W'(1);
						state_q <= S_EMIT;
					end
				end
				S_INS_FIN: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_EMIT;
				end
				S_HEAD_RD: begin
					state_q <= S_HEAD_USE;
				end
				S_HEAD_USE: begin
					owner_q <= ram_rdata.tid;
					nest_q  <= NEST_ONE;
					base_q  <= ram_rdata.prio;
					eff_q   <= ram_rdata.prio;
					idx_q   <= '0;
					state_q <= S_SHF_RD;
				end
				S_SHF_RD: begin
					if (idx_nx < count_q) begin
						state_q <= S_SHF_WR;
					end else begin
						count_q <= count_q - CNT_W'(1);
						state_q <= S_EMIT;
					end
				end
				S_SHF_WR: begin
					idx_q   <= IDX_W'(idx_nx);
					state_q <= S_SHF_RD;
				end
				S_RM_RD: begin
					state_q <= S_RM_CMP;
				end
				S_RM_CMP: begin
					if (ram_rdata.tid == req_tid_q) begin
						state_q <= S_SHF_RD;
					end else if (idx_nx < count_q) begin
						idx_q   <= IDX_W'(idx_nx);
						state_q <= S_RM_RD;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_DEL_RD: begin
					state_q <= S_DEL_OUT;
				end
				S_DEL_OUT: begin
					if (res_ready) begin
						if (del_last) begin
							owned_q <= 1'b0;
							nest_q  <= '0;
							count_q <= '0;
							state_q <= S_IDLE;
						end else begin
							idx_q   <= IDX_W'(idx_nx);
							state_q <= S_DEL_RD;
						end
					end
				end
				S_EMIT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/priority_inheritance_mutex_core.sv -----
// ----------------------------------------------------------------------------
// priority_inheritance_mutex_core
// Recursive mutex with priority inheritance and a priority-sorted wait queue.
// ----------------------------------------------------------------------------
// One request item in, one result item out (delete gives one per released
// waiter, the final one marked by tlast). The block handles one request at a
// time. A queued lock into an empty queue writes slot 0 directly; otherwise
// it walks the queue from the tail, moving each entry of lower priority back
// by one slot. A final unlock with waiters grants the head and shifts the
// rest forward; a remove scans for its task and shifts the entries behind it
// forward; delete reads out one released waiter per result item. The walks
// go through the wait queue memory, which has one read port with a registered
// read, so each entry visited takes a read state and a compare/write state.
// Lower priority numbers are higher priority, equal priorities queue in
// arrival order, and priorities at or above PRIO_LEVELS are saturated to
// PRIO_LEVELS-1. A result waits in an output register until taken, so the
// downstream side may stall freely. The queue memory needs no clearing after
// reset: only entries below the waiter count are ever read.
// ----------------------------------------------------------------------------
module priority_inheritance_mutex_core #(
	parameter int NUM_TASKS   = pim_pkg::NUM_TASKS_DEF,
	parameter int PRIO_LEVELS = pim_pkg::PRIO_LEVELS_DEF,
	parameter int MAX_NEST    = pim_pkg::MAX_NEST_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [1:0] action, [5:2] task_id, [10:6] task_priority, [11] no_wait
	input  logic [15:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [2:0] status, [3] prio_change_valid, [7:4] prio_task, [12:8] prio_value,
	// [13] wake_valid, [17:14] wake_task, [18] wake_timed_out, [19] yield_hint
	output logic [23:0] m_axis_tdata,
	output logic        m_axis_tlast
);
	import pim_pkg::*;

	localparam int IDX_W = $clog2(NUM_TASKS);

	req_t             req;
	logic             res_valid;
	logic             res_ready;
	result_t          res;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	waiter_t          ram_wdata;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	waiter_t          ram_rdata;

	logic             out_valid_q;
	result_t          out_q;

	// unpack the request item
	always_comb begin
		req.action        = action_t'(s_axis_tdata[1:0]);
		req.task_id       = s_axis_tdata[5:2];
		req.task_priority = s_axis_tdata[10:6];
		req.no_wait       = s_axis_tdata[11];
	end

	pim_seq #(
		.NUM_TASKS   (NUM_TASKS),
		.PRIO_LEVELS (PRIO_LEVELS),
		.MAX_NEST    (MAX_NEST),
		.IDX_W       (IDX_W)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	pim_waitq_ram #(
		.DEPTH (NUM_TASKS),
		.AW    (IDX_W)
	) u_waitq (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register: slot frees when empty or being taken this cycle
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (res_valid && res_ready) begin
				out_valid_q <= 1'b1;
				out_q       <= res;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// pack the result item
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_q.last;
	assign m_axis_tdata  = {
		4'b0000,
		out_q.yield_hint,
		out_q.wake_timed_out,
		out_q.wake_task,
		out_q.wake_valid,
		out_q.prio_value,
		out_q.prio_task,
		out_q.prio_change_valid,
		out_q.status
	};

endmodule

// ----- tb/tb_priority_inheritance_mutex_core.sv -----
// ----------------------------------------------------------------------------
// tb_priority_inheritance_mutex_core
// Self-checking bench for the priority inheritance mutex core: a cycle-free
// model of the mutex predicts every result item from the accepted request
// items, a checker compares each result field by field, and the run goes
// through directed cases, nest and queue limits, a long output hold-off and
// a random mix with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb_priority_inheritance_mutex_core;
	import pim_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 7;
	localparam int RANDOM_REQS   = 118;
	localparam int PRESSURE_REQS = 30;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 64;
	// worst case per item is a 16-result delete behind a stalling receiver
	localparam int CYCLE_LIMIT   = 400000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// [1:0] action, [5:2] task_id, [10:6] task_priority, [11] no_wait
	logic [15:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// [2:0] status, [3] prio_change_valid, [7:4] prio_task, [12:8] prio_value,
	// [13] wake_valid, [17:14] wake_task, [18] wake_timed_out, [19] yield_hint
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast;

	priority_inheritance_mutex_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #CLK_HALF clk = ~clk;

	// ------------------------------------------------------------------
	// Mutex model state, kept in step with every accepted request item.
	// ------------------------------------------------------------------
	logic              mx_owned = 1'b0;
	logic [TASK_W-1:0] mx_owner = '0;
	int unsigned       mx_nest  = 0;
	logic [PRIO_W-1:0] mx_base  = '0;
	logic [PRIO_W-1:0] mx_eff   = '0;
	waiter_t           waitq_model[$];      // sorted by prio, FIFO within a level
	result_t           pending_results[$];  // results owed by the core, oldest first

	// bookkeeping
	int errors        = 0;
	int reqs_sent     = 0;
	int results_seen  = 0;
	int timeout_wakes = 0;
	int yields        = 0;
	int status_seen[8];
	int cycle_count   = 0;

	// sender pacing
	bit gaps_on    = 1'b1;
	int burst_left = 0;

	// receiver hold-off request: bump hold_epoch, the receiver counts it out
	int hold_epoch = 0;
	int hold_len   = 0;
	int hold_seen  = 0;
	int hold_left  = 0;

	// ------------------------------------------------------------------
	// Model: one request item in, its result items pushed on the queue.
	// ------------------------------------------------------------------
	task automatic apply_request(input req_t r);
		result_t           res;
		logic [PRIO_W-1:0] prio;
		logic [PRIO_W-1:0] old_base;
		waiter_t           head;
		waiter_t           w;
		int                pos;
		int                n;
		begin
			res      = '0;
			res.last = 1'b1;
			prio     = r.task_priority;
			// priorities past the last level clamp to the lowest one
			if (int'(prio) > PRIO_LEVELS_DEF - 1)
				prio = PRIO_W'(PRIO_LEVELS_DEF - 1);

			case (r.action)
				ACT_LOCK: begin
					if (!mx_owned) begin
						mx_owned   = 1'b1;
						mx_owner   = r.task_id;
						mx_nest    = 1;
						mx_base    = prio;
						mx_eff     = prio;
						res.status = ST_OK;
					end else if (mx_owner == r.task_id) begin
						// recursive lock, refused once the nest count is full
						if (mx_nest >= MAX_NEST_DEF) begin
							res.status = ST_NEST_OVF;
						end else begin
							mx_nest++;
							res.status = ST_OK;
						end
					end else begin
						// contended: inherit first, then refuse or queue
						if (prio < mx_eff) begin
							mx_eff                = prio;
							res.prio_change_valid = 1'b1;
							res.prio_task         = mx_owner;
							res.prio_value        = prio;
						end
						if (r.no_wait || waitq_model.size() >= NUM_TASKS_DEF) begin
							res.status = ST_WOULD_BLOCK;
						end else begin
							pos = 0;
							while (pos < waitq_model.size() && waitq_model[pos].prio <= prio)
								pos++;
							w.tid  = r.task_id;
							w.prio = prio;
							waitq_model.insert(pos, w);
							res.status = ST_QUEUED;
						end
					end
				end
				ACT_UNLOCK: begin
					if (!mx_owned || mx_owner != r.task_id) begin
						res.status = ST_NOT_OWNER;
					end else begin
						res.status = ST_OK;
						if (mx_nest > 0)
							mx_nest--;
						if (mx_nest == 0) begin
							// final unlock: owner falls back to its base priority
							old_base              = mx_base;
							res.prio_change_valid = 1'b1;
							res.prio_task         = mx_owner;
							res.prio_value        = mx_base;
							mx_eff                = mx_base;
							if (waitq_model.size() > 0) begin
								head           = waitq_model.pop_front();
								mx_owner       = head.tid;
								mx_nest        = 1;
								mx_base        = head.prio;
								mx_eff         = head.prio;
								res.wake_valid = 1'b1;
								res.wake_task  = head.tid;
								res.yield_hint = head.prio < old_base;
							end else begin
								mx_owned = 1'b0;
							end
						end
					end
				end
				ACT_REMOVE: begin
					// earliest entry of that task goes; no priority is recomputed
					res.status = ST_NOT_WAITING;
					for (pos = 0; pos < waitq_model.size(); pos++) begin
						if (waitq_model[pos].tid == r.task_id) begin
							waitq_model.delete(pos);
							res.status = ST_OK;
							break;
						end
					end
				end
				default: begin
					// delete: restore rides on the first item, one item per waiter
					n          = waitq_model.size();
					res.status = ST_OK;
					if (mx_owned) begin
						mx_eff                = mx_base;
						res.prio_change_valid = 1'b1;
						res.prio_task         = mx_owner;
						res.prio_value        = mx_base;
					end
					if (n == 0)
						pending_results.push_back(res);
					for (pos = 0; pos < n; pos++) begin
						if (pos > 0) begin
							res.prio_change_valid = 1'b0;
							res.prio_task         = '0;
							res.prio_value        = '0;
						end
						res.wake_valid     = 1'b1;
						res.wake_task      = waitq_model[pos].tid;
						res.wake_timed_out = 1'b1;
						res.last           = (pos == n - 1);
						pending_results.push_back(res);
					end
					mx_owned = 1'b0;
					mx_nest  = 0;
					waitq_model.delete();
				end
			endcase

			if (r.action != ACT_DELETE)
				pending_results.push_back(res);
		end
	endtask

	// ------------------------------------------------------------------
	// Sender: bursts of random length with random gaps between them.
	// Data is junk while tvalid is low.
	// ------------------------------------------------------------------
	task automatic pace();
		int gap;
		begin
			if (!gaps_on)
				return;
			if (burst_left == 0) begin
				gap = $urandom_range(1, 8);
				repeat (gap) begin
					@(negedge clk);
					s_axis_tvalid = 1'b0;
					s_axis_tdata  = {4'b0, 12'($urandom)};
				end
				burst_left = $urandom_range(1, 12);
				// now and then a long stretch with no gaps at all
				if ($urandom_range(0, 9) == 0)
					burst_left = 40;
			end
			burst_left--;
		end
	endtask

	// drive one request item and wait until the core takes it
	task automatic send_req(input req_t r);
		begin
			pace();
			@(negedge clk);
			s_axis_tvalid = 1'b1;
			s_axis_tdata  = {4'b0, r.no_wait, r.task_priority, r.task_id, r.action};
			do
				@(posedge clk);
			while (!s_axis_tready);
			apply_request(r);
			reqs_sent++;
		end
	endtask

	task automatic issue(input action_t act, input int tid, input int prio, input bit nw);
		req_t r;
		begin
			r.action        = act;
			r.task_id       = TASK_W'(tid);
			r.task_priority = PRIO_W'(prio);
			r.no_wait       = nw;
			send_req(r);
		end
	endtask

	// sender goes quiet, then waits for every owed result
	task automatic wait_drained();
		begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			while (pending_results.size() != 0)
				@(posedge clk);
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// every action, inheritance, FIFO ties, duplicates, edge ids and prios
	task automatic test_directed();
		begin
			issue(ACT_LOCK,    3, 10, 0);  // free mutex taken
			issue(ACT_LOCK,    3, 10, 0);  // re-lock by owner
			issue(ACT_LOCK,    5, 12, 1);  // no_wait, lower prio: no boost
			issue(ACT_LOCK,    7,  4, 0);  // boost owner to 4, queue
			issue(ACT_LOCK,    9,  4, 0);  // equal prio queues behind task 7
			issue(ACT_LOCK,    1, 31, 0);  // tail of queue
			issue(ACT_LOCK,    7,  0, 0);  // duplicate waiter, boost to 0, head
			issue(ACT_LOCK,   15, 31, 0);
			issue(ACT_REMOVE,  1,  0, 0);
			issue(ACT_REMOVE,  2,  0, 0);  // not waiting
			issue(ACT_REMOVE,  7,  0, 0);  // earliest entry of task 7 only
			issue(ACT_UNLOCK,  5,  0, 0);  // not the owner
			issue(ACT_UNLOCK,  3,  0, 0);  // nest 2 -> 1
			issue(ACT_UNLOCK,  3,  0, 0);  // restore, grant with yield
			issue(ACT_UNLOCK,  7,  0, 0);  // grant at equal prio, no yield
			issue(ACT_DELETE,  0,  0, 0);  // restore plus one timed-out release
			issue(ACT_DELETE,  0,  0, 0);  // free and empty
			issue(ACT_UNLOCK,  0,  0, 0);  // unlock of a free mutex
			issue(ACT_LOCK,   15, 31, 0);
			issue(ACT_LOCK,    0,  0, 1);  // strongest boost, refused
			issue(ACT_REMOVE, 15, 31, 1);  // owner is not a waiter
			issue(ACT_DELETE, 15,  0, 0);  // restore only
			wait_drained();
		end
	endtask

	// fill the nest count, then push past it
	task automatic test_nest_overflow();
		begin
			repeat (MAX_NEST_DEF) issue(ACT_LOCK, 6, 20, 0);
			issue(ACT_LOCK,   6,  20, 0);   // refused
			issue(ACT_LOCK,   6,   3, 1);   // still refused, no change
			issue(ACT_UNLOCK, 6,   0, 0);
			issue(ACT_LOCK,   6,  20, 0);   // back at the limit
			issue(ACT_LOCK,   6,  20, 0);   // refused again
			issue(ACT_LOCK,   8,   2, 0);   // boost and queue behind owner
			issue(ACT_DELETE, 0,   0, 0);
			wait_drained();
		end
	endtask

	// full wait queue, then the largest delete
	task automatic test_queue_full();
		begin
			issue(ACT_LOCK, 2, 16, 0);
			repeat (NUM_TASKS_DEF)
				issue(ACT_LOCK, (2 + $urandom_range(1, 15)) % 16, $urandom_range(0, 31), 0);
			issue(ACT_LOCK,   11, 1, 0);    // queue full: boost only if higher, would_block
			issue(ACT_LOCK,   12, 0, 0);
			issue(ACT_DELETE,  0, 0, 0);    // sixteen released
			issue(ACT_LOCK,    2, 16, 0);
			repeat (4)
				issue(ACT_LOCK, $urandom_range(3, 15), $urandom_range(0, 31), 0);
			issue(ACT_UNLOCK, 2, 0, 0);
			issue(ACT_UNLOCK, mx_owner, 0, 0);
			issue(ACT_DELETE, 0, 0, 0);
			wait_drained();
		end
	endtask

	// mix of well-formed traffic and noise; owners and waiters are picked
	// from the model so that handoffs and removes happen often
	task automatic test_random(input int count);
		req_t r;
		int   pick;
		begin
			for (int i = 0; i < count; i++) begin
				pick            = $urandom_range(0, 99);
				r.task_id       = TASK_W'($urandom);
				r.task_priority = PRIO_W'($urandom);
				r.no_wait       = ($urandom_range(0, 3) == 0);
				if (pick < 45) begin
					r.action = ACT_LOCK;
					if (mx_owned && $urandom_range(0, 4) == 0)
						r.task_id = mx_owner;
				end else if (pick < 75) begin
					r.action = ACT_UNLOCK;
					if (mx_owned && $urandom_range(0, 4) != 0)
						r.task_id = mx_owner;
				end else if (pick < 93) begin
					r.action = ACT_REMOVE;
					if (waitq_model.size() > 0 && $urandom_range(0, 3) != 0)
						r.task_id = waitq_model[$urandom_range(0, waitq_model.size() - 1)].tid;
				end else begin
					r.action = ACT_DELETE;
				end
				send_req(r);
			end
		end
	endtask

	// receiver holds off for a long time while the sender keeps offering
	task automatic test_backpressure();
		begin
			gaps_on  = 1'b0;
			hold_len = HOLD_CYCLES;
			hold_epoch++;
			test_random(PRESSURE_REQS);
			gaps_on  = 1'b1;
			wait_drained();   // sender quiet until everything is back
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver: own stall pattern in segments (always ready, coin flip,
	// mostly stalled), plus hold-offs counted out here.
	// ------------------------------------------------------------------
	initial begin
		int seg;
		int mode;
		m_axis_tready = 1'b0;
		seg           = 0;
		mode          = 0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_epoch) begin
				hold_seen = hold_epoch;
				hold_left = hold_len;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready = 1'b0;
			end else begin
				if (seg == 0) begin
					seg  = $urandom_range(8, 64);
					mode = $urandom_range(0, 2);
				end
				seg--;
				case (mode)
					0:       m_axis_tready = 1'b1;
					1:       m_axis_tready = 1'($urandom_range(0, 1));
					default: m_axis_tready = ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker
	// ------------------------------------------------------------------
	function automatic void check_field(input string name, input int unsigned want,
	                                    input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			status_seen[m_axis_tdata[2:0]]++;
			if (m_axis_tdata[18])
				timeout_wakes++;
			if (m_axis_tdata[19])
				yields++;
			if (pending_results.size() == 0) begin
				$error("unexpected result item: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("status",            want.status,            m_axis_tdata[2:0]);
				check_field("prio_change_valid", want.prio_change_valid, m_axis_tdata[3]);
				check_field("prio_task",         want.prio_task,         m_axis_tdata[7:4]);
				check_field("prio_value",        want.prio_value,        m_axis_tdata[12:8]);
				check_field("wake_valid",        want.wake_valid,        m_axis_tdata[13]);
				check_field("wake_task",         want.wake_task,         m_axis_tdata[17:14]);
				check_field("wake_timed_out",    want.wake_timed_out,    m_axis_tdata[18]);
				check_field("yield_hint",        want.yield_hint,        m_axis_tdata[19]);
				check_field("last",              want.last,              m_axis_tlast);
			end
		end
	end

	// hang guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_nest_overflow();
		test_queue_full();
		test_backpressure();
		test_random(RANDOM_REQS);

		@(negedge clk);
		s_axis_tvalid = 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run: %0d requests, %0d results; ok %0d, would_block %0d, queued %0d",
		         reqs_sent, results_seen, status_seen[ST_OK], status_seen[ST_WOULD_BLOCK],
		         status_seen[ST_QUEUED]);
		$display("run: not_owner %0d, nest_overflow %0d, not_waiting %0d, timed-out %0d, yield %0d",
		         status_seen[ST_NOT_OWNER], status_seen[ST_NEST_OVF],
		         status_seen[ST_NOT_WAITING], timeout_wakes, yields);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/pim_pkg.sv
rtl/core/pim_waitq_ram.sv
rtl/core/pim_seq.sv
rtl/core/priority_inheritance_mutex_core.sv
tb/tb_priority_inheritance_mutex_core.sv
